### hw/rtl/kb_mac_pkg.sv
`default_nettype none

package kb_mac_pkg;

  typedef enum logic [1:0] {
    PH_TEXT   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_KEY    = 2'd2,
    PH_DELAY  = 2'd3
  } phase_t;

  localparam logic [2:0] TK_TEXT  = 3'd0;
  localparam logic [2:0] TK_TAP   = 3'd1;
  localparam logic [2:0] TK_UP    = 3'd3;
  localparam logic [2:0] TK_DELAY = 3'd4;
  localparam logic [2:0] TK_END   = 3'd5;

  localparam logic [7:0] BYTE_END    = 8'h00;
  localparam logic [7:0] BYTE_PREFIX = 8'h01;
  localparam logic [7:0] CODE_DELAY  = 8'h04;
  localparam logic [7:0] BYTE_BAR    = 8'h7C;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_NINE   = 8'h39;

  localparam logic [7:0] MACRO_COUNT_RESET = 8'd16;

endpackage

`default_nettype wire

### hw/rtl/keyboard_macro_stream_parser.sv
// A token is registered and appears on the output in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the only stall is a held token at the output.
// The output register frees in the same cycle its token is taken.
// Reset (rst, synchronous): parse state cleared, no token held, macro_count = 16.
// The last byte of a buffer clears the parse state but keeps macro_count.
`default_nettype none

module keyboard_macro_stream_parser
  import kb_mac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       macro_count_write,
  input  wire logic [7:0] macro_count_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_in_buffer,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      token_kind,
  output logic [7:0]      key_or_char,
  output logic [15:0]     delay_ms,
  output logic [7:0]      macro_number
);

  logic [7:0]  macro_count;
  phase_t      phase, phase_next;
  logic [1:0]  pending_op, pending_op_next;
  logic [15:0] delay_accum, delay_accum_next;
  logic        digits_closed, digits_closed_next;
  logic [7:0]  current_macro, current_macro_next;

  logic        in_accept;
  logic        emit;
  logic [2:0]  res_kind;
  logic [7:0]  res_key;
  logic [15:0] res_ms;
  logic        is_digit;
  logic [15:0] accum_times_ten;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign is_digit = (data_byte >= BYTE_ZERO) && (data_byte <= BYTE_NINE);
  assign accum_times_ten = {delay_accum[12:0], 3'b000} + {delay_accum[14:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      macro_count <= MACRO_COUNT_RESET;
    end else if (macro_count_write) begin
      macro_count <= macro_count_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TEXT;
      pending_op    <= 2'd0;
      delay_accum   <= 16'd0;
      digits_closed <= 1'b0;
      current_macro <= 8'd0;
    end else if (in_accept) begin
      phase         <= phase_next;
      pending_op    <= pending_op_next;
      delay_accum   <= delay_accum_next;
      digits_closed <= digits_closed_next;
      current_macro <= current_macro_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    pending_op_next    = pending_op;
    delay_accum_next   = delay_accum;
    digits_closed_next = digits_closed;
    current_macro_next = current_macro;
    emit     = 1'b0;
    res_kind = TK_TEXT;
    res_key  = 8'd0;
    res_ms   = 16'd0;

    if (current_macro < macro_count) begin
      case (phase)
        PH_PREFIX: begin
          if (data_byte >= 8'd1 && data_byte <= {5'd0, TK_UP}) begin
            pending_op_next = data_byte[1:0];
            phase_next      = PH_KEY;
          end else if (data_byte == CODE_DELAY) begin
            delay_accum_next   = 16'd0;
            digits_closed_next = 1'b0;
            phase_next         = PH_DELAY;
          end else begin
            phase_next = PH_TEXT;
          end
        end
        PH_KEY: begin
          emit            = 1'b1;
          res_kind        = {1'b0, pending_op};
          res_key         = data_byte;
          pending_op_next = 2'd0;
          phase_next      = PH_TEXT;
        end
        PH_DELAY: begin
          if (data_byte == BYTE_BAR) begin
            emit               = 1'b1;
            res_kind           = TK_DELAY;
            res_ms             = delay_accum;
            delay_accum_next   = 16'd0;
            digits_closed_next = 1'b0;
            phase_next         = PH_TEXT;
          end else if (!digits_closed && is_digit) begin
            delay_accum_next = accum_times_ten + {12'd0, data_byte[3:0]};
          end else begin
            digits_closed_next = 1'b1;
          end
        end
        default: begin
          if (data_byte == BYTE_END) begin
            emit               = 1'b1;
            res_kind           = TK_END;
            current_macro_next = current_macro + 8'd1;
          end else if (data_byte == BYTE_PREFIX) begin
            phase_next = PH_PREFIX;
          end else begin
            emit     = 1'b1;
            res_kind = TK_TEXT;
            res_key  = data_byte;
          end
        end
      endcase
    end

    if (last_in_buffer) begin
      if (phase_next == PH_DELAY && !emit) begin
        emit     = 1'b1;
        res_kind = TK_DELAY;
        res_key  = 8'd0;
        res_ms   = delay_accum_next;
      end
      phase_next         = PH_TEXT;
      pending_op_next    = 2'd0;
      delay_accum_next   = 16'd0;
      digits_closed_next = 1'b0;
      current_macro_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      token_kind   <= res_kind;
      key_or_char  <= res_key;
      delay_ms     <= res_ms;
      macro_number <= current_macro;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_in_buffer |=> phase == PH_TEXT && current_macro == 8'd0
      && delay_accum == 16'd0)
    else $error("parse state not cleared after last byte");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= TK_END)
    else $error("token kind out of range");

  a_ms_only_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != TK_DELAY |-> delay_ms == 16'd0)
    else $error("delay value on non-delay token");

  a_key_token: assert property (@(posedge clk) disable iff (rst)
    in_accept && phase == PH_KEY && current_macro < macro_count
      |=> out_valid && token_kind >= TK_TAP && token_kind <= TK_UP
        && key_or_char == $past(data_byte))
    else $error("keycode byte did not give a key token");

  a_macro_step: assert property (@(posedge clk) disable iff (rst)
    in_accept && !last_in_buffer
      |=> current_macro == $past(current_macro)
        || current_macro == $past(current_macro) + 8'd1)
    else $error("macro index jumped");

endmodule

`default_nettype wire
